>>> rtl/desp_pkg.sv
// ----------------------------------------------------------------------------
// desp_pkg
// Shared types and constants for the DER ECDSA signature parser: parse
// phases, parse state, result word layout and the framing constants.
// ----------------------------------------------------------------------------
package desp_pkg;

	// Largest coordinate the block right-aligns into
	localparam int MAX_COORD_BYTES = 48;
	localparam int COORD_BYTES_W   = 6;
	localparam logic [COORD_BYTES_W-1:0] COORD_BYTES_RESET = 6'd32;

	// DER framing
	localparam logic [7:0]  TAG_SEQUENCE  = 8'h30;
	localparam logic [7:0]  TAG_INTEGER   = 8'h02;
	localparam logic [6:0]  LONG_FORM_MAX = 7'd4;
	localparam logic [31:0] LONG_FORM_MIN = 32'd128;

	// Output queue depth (a final byte can push two words)
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	typedef logic [COORD_BYTES_W-1:0] coord_bytes_t;

	// Result word kinds
	typedef enum logic [1:0] {
		KIND_R       = 2'd0,
		KIND_S       = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_SEQ_TAG,
		PH_SEQ_LEN,
		PH_SEQ_LENX,
		PH_INT_TAG,
		PH_INT_LEN,
		PH_INT_LENX,
		PH_INT_FIRST,
		PH_INT_BODY,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] seq_left;
		logic [31:0] acc;
		logic [2:0]  len_left;
		logic [31:0] elem_left;
		logic [5:0]  vpos;
		logic        cur_int;
		logic        err;
	} parse_t;

	localparam parse_t PARSE_RESET = '{
		phase:     PH_SEQ_TAG,
		seq_left:  32'd0,
		acc:       32'd0,
		len_left:  3'd0,
		elem_left: 32'd0,
		vpos:      6'd0,
		cur_int:   1'b0,
		err:       1'b0
	};

	typedef struct packed {
		kind_t      kind;
		logic [5:0] position;
		logic [7:0] value;
		logic       ok;
		logic       last;
	} result_t;

	// Words produced by one byte: an optional data word, then an optional verdict
	typedef struct packed {
		logic    data_v;
		result_t data;
		logic    verdict_v;
		result_t verdict;
	} step_out_t;

endpackage

>>> rtl/desp_byte_if.sv
// ----------------------------------------------------------------------------
// desp_byte_if
// Signature byte channel: valid/ready handshake with the byte and its
// final-byte flag.
// ----------------------------------------------------------------------------
interface desp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] sig_byte;
	logic       is_last;

	modport source(output valid, output sig_byte, output is_last, input ready);
	modport sink(input valid, input sig_byte, input is_last, output ready);
endinterface

>>> rtl/desp_res_if.sv
// ----------------------------------------------------------------------------
// desp_res_if
// Result channel: valid/ready handshake with coordinate bytes and verdicts.
// ----------------------------------------------------------------------------
interface desp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [5:0] position;
	logic [7:0] value;
	logic       ok;
	logic       last;

	modport source(output valid, output kind, output position, output value,
		output ok, output last, input ready);
	modport sink(input valid, input kind, input position, input value,
		input ok, input last, output ready);
endinterface

>>> rtl/desp_step.sv
// ----------------------------------------------------------------------------
// desp_step
// Next-state and result logic for one signature byte: DER tag and length
// checks, leading-zero drop, right alignment and the final verdict.
// ----------------------------------------------------------------------------
module desp_step (
	input  desp_pkg::parse_t       cur,
	input  logic [7:0]             sig_byte,
	input  logic                   is_last,
	input  desp_pkg::coord_bytes_t coord_bytes,
	output desp_pkg::parse_t       nxt,
	output desp_pkg::step_out_t    res
);
	import desp_pkg::*;

	logic        in_int;
	logic        coord_bad;
	logic [6:0]  lf_cnt;
	logic        lf_bad;
	logic [31:0] seq_dec;
	logic [31:0] acc_new;
	logic [2:0]  ll_new;
	logic [31:0] elem_dec;
	logic [31:0] n;
	logic [5:0]  vpos_sel;
	logic        keep;
	logic        do_adv;

	// Terms computed ahead of the phase decode
	assign in_int    = (cur.phase != PH_SEQ_TAG) && (cur.phase != PH_SEQ_LEN) &&
		(cur.phase != PH_SEQ_LENX);
	assign coord_bad = (coord_bytes == '0) ||
		(coord_bytes > COORD_BYTES_W'(MAX_COORD_BYTES));
	assign lf_cnt    = sig_byte[6:0];
	assign lf_bad    = (lf_cnt == 7'd0) || (lf_cnt > LONG_FORM_MAX);
	assign seq_dec   = cur.seq_left - 32'd1;
	assign acc_new   = {cur.acc[23:0], sig_byte};
	assign ll_new    = cur.len_left - 3'd1;
	assign elem_dec  = cur.elem_left - 32'd1;

	// Parse one byte
	always_comb begin
		nxt      = cur;
		keep     = 1'b0;
		do_adv   = 1'b0;
		n        = cur.elem_left;
		vpos_sel = cur.vpos;
		res      = '0;

		if (!cur.err) begin
			if (coord_bad || (cur.phase == PH_DONE)) begin
				nxt.err = 1'b1;
			end else if (in_int && (cur.seq_left == 32'd0)) begin
				nxt.err = 1'b1;
			end else begin
				if (in_int) begin
					nxt.seq_left = seq_dec;
				end
				unique case (cur.phase)
					PH_SEQ_TAG: begin
						if (sig_byte != TAG_SEQUENCE) nxt.err = 1'b1;
						else nxt.phase = PH_SEQ_LEN;
					end
					PH_SEQ_LEN: begin
						if (sig_byte[7]) begin
							if (lf_bad) begin
								nxt.err = 1'b1;
							end else begin
								nxt.len_left = lf_cnt[2:0];
								nxt.acc      = 32'd0;
								nxt.phase    = PH_SEQ_LENX;
							end
						end else begin
							nxt.seq_left = {24'd0, sig_byte};
							nxt.phase    = PH_INT_TAG;
						end
					end
					PH_SEQ_LENX, PH_INT_LENX: begin
						nxt.acc      = acc_new;
						nxt.len_left = ll_new;
						if (ll_new == 3'd0) begin
							if (acc_new < LONG_FORM_MIN) begin
								nxt.err = 1'b1;
							end else if (cur.phase == PH_SEQ_LENX) begin
								nxt.seq_left = acc_new;
								nxt.phase    = PH_INT_TAG;
							end else if (acc_new > seq_dec) begin
								nxt.err = 1'b1;
							end else begin
								nxt.elem_left = acc_new;
								nxt.phase     = PH_INT_FIRST;
							end
						end
					end
					PH_INT_TAG: begin
						if (sig_byte != TAG_INTEGER) nxt.err = 1'b1;
						else nxt.phase = PH_INT_LEN;
					end
					PH_INT_LEN: begin
						if (sig_byte[7]) begin
							if (lf_bad) begin
								nxt.err = 1'b1;
							end else begin
								nxt.len_left = lf_cnt[2:0];
								nxt.acc      = 32'd0;
								nxt.phase    = PH_INT_LENX;
							end
						end else if ((sig_byte == 8'd0) || ({24'd0, sig_byte} > seq_dec)) begin
							nxt.err = 1'b1;
						end else begin
							nxt.elem_left = {24'd0, sig_byte};
							nxt.phase     = PH_INT_FIRST;
						end
					end
					PH_INT_FIRST: begin
						if (sig_byte[7]) begin
							nxt.err = 1'b1;
						end else begin
							// drop one leading zero when more bytes follow
							keep = 1'b1;
							if ((cur.elem_left > 32'd1) && (sig_byte == 8'd0)) begin
								keep = 1'b0;
								n    = elem_dec;
							end
							if (n > {26'd0, coord_bytes}) begin
								nxt.err = 1'b1;
							end else begin
								vpos_sel = coord_bytes - n[5:0];
								do_adv   = 1'b1;
							end
						end
					end
					PH_INT_BODY: begin
						keep   = 1'b1;
						do_adv = 1'b1;
					end
					default: begin
						nxt.err = 1'b1;
					end
				endcase

				// Advance through the integer content
				if (do_adv) begin
					nxt.elem_left = elem_dec;
					nxt.vpos      = vpos_sel;
					if (elem_dec != 32'd0) begin
						nxt.phase = PH_INT_BODY;
					end else if (!cur.cur_int) begin
						nxt.cur_int = 1'b1;
						nxt.phase   = PH_INT_TAG;
					end else begin
						nxt.phase = PH_DONE;
						if (nxt.seq_left != 32'd0) nxt.err = 1'b1;
					end
					if (keep && !nxt.err) begin
						res.data_v        = 1'b1;
						res.data.kind     = cur.cur_int ? KIND_S : KIND_R;
						res.data.position = vpos_sel;
						res.data.value    = sig_byte;
						nxt.vpos          = vpos_sel + 6'd1;
					end
				end
			end
		end

		// Close the signature on the final byte
		if (is_last) begin
			res.verdict_v    = 1'b1;
			res.verdict.kind = KIND_VERDICT;
			res.verdict.ok   = !nxt.err && (nxt.phase == PH_DONE) &&
				(nxt.seq_left == 32'd0);
			res.verdict.last = 1'b1;
			nxt              = PARSE_RESET;
		end
	end

endmodule

>>> rtl/desp_out_fifo.sv
// ----------------------------------------------------------------------------
// desp_out_fifo
// Small result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module desp_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  desp_pkg::step_out_t push,
	input  logic                pop,
	output desp_pkg::result_t   head,
	output logic                not_empty,
	output logic                room
);
	import desp_pkg::*;

	result_t           mem_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wp_q;
	logic [OUT_AW-1:0] rp_q;
	logic [OUT_CW-1:0] count_q;
	logic [1:0]        n_push;
	logic [OUT_AW-1:0] wa;
	logic [OUT_AW-1:0] wb;

	assign n_push    = push_en ? ({1'b0, push.data_v} + {1'b0, push.verdict_v}) : 2'd0;
	assign wa        = wp_q;
	assign wb        = wp_q + OUT_AW'(1);
	assign head      = mem_q[rp_q];
	assign not_empty = (count_q != '0);
	assign room      = (count_q <= OUT_CW'(OUT_DEPTH - 2));

	// Store pushed words, verdict packed behind the data word
	always_ff @(posedge clk) begin
		if (push_en) begin
			if (push.data_v) mem_q[wa] <= push.data;
			if (push.verdict_v) begin
				if (push.data_v) mem_q[wb] <= push.verdict;
				else mem_q[wa] <= push.verdict;
			end
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + OUT_AW'(n_push);
			if (pop) rp_q <= rp_q + OUT_AW'(1);
			count_q <= count_q + OUT_CW'(n_push) - OUT_CW'(pop);
		end
	end

endmodule

>>> rtl/der_ecdsa_signature_parser_core.sv
// ----------------------------------------------------------------------------
// der_ecdsa_signature_parser_core
// DER ECDSA signature parser: checks SEQUENCE { INTEGER r, INTEGER s } framing
// and emits right-aligned r and s bytes followed by a verdict word.
// ----------------------------------------------------------------------------
// Each byte goes through the input byte register and the combinational parse
// step into the output queue, whose head offers the result. Throughput: one
// byte per cycle while the queue has room; a final byte that also carries data
// yields two words, which the queue drains at one word per cycle while res.ready is high.
// Reset: arst_n clears parse state and the output queue, coord_bytes goes to 32.
module der_ecdsa_signature_parser_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  desp_pkg::coord_bytes_t cfg_wdata,
	desp_byte_if.sink              sig,
	desp_res_if.source             res
);
	import desp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	parse_t       parse_q;
	parse_t       parse_nxt;
	coord_bytes_t coord_bytes_q;
	step_out_t    step_res;
	result_t      head;
	logic         q_room;
	logic         q_not_empty;
	logic         advance;

	assign advance   = valid_s1 && q_room;
	assign sig.ready = !valid_s1 || advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_bytes_q <= COORD_BYTES_RESET;
		end else if (cfg_we) begin
			coord_bytes_q <= cfg_wdata;
		end
	end

	// Input byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sig.valid && sig.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sig.valid && sig.ready) begin
			byte_s1 <= sig.sig_byte;
			last_s1 <= sig.is_last;
		end
	end

	// Parse state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= PARSE_RESET;
		end else if (advance) begin
			parse_q <= parse_nxt;
		end
	end

	desp_step u_step (
		.cur         (parse_q),
		.sig_byte    (byte_s1),
		.is_last     (last_s1),
		.coord_bytes (coord_bytes_q),
		.nxt         (parse_nxt),
		.res         (step_res)
	);

	desp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (advance),
		.push      (step_res),
		.pop       (res.valid && res.ready),
		.head      (head),
		.not_empty (q_not_empty),
		.room      (q_room)
	);

	// Drive the result channel from the queue head
	assign res.valid    = q_not_empty;
	assign res.kind     = head.kind;
	assign res.position = head.position;
	assign res.value    = head.value;
	assign res.ok       = head.ok;
	assign res.last     = head.last;

endmodule

>>> rtl/desp_checker.sv
// ----------------------------------------------------------------------------
// desp_checker
// Port-level checks for the DER ECDSA signature parser, bound to the top.
// ----------------------------------------------------------------------------
module desp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_is_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [5:0] out_position,
	input logic [7:0] out_value,
	input logic       out_ok,
	input logic       out_last
);
	import desp_pkg::*;

	logic [2:0] pending_q;
	logic       in_fin;
	logic       out_fin;

	assign in_fin  = in_valid && in_ready && in_is_last;
	assign out_fin = out_valid && out_ready && (out_kind == KIND_VERDICT);

	// Track final bytes taken whose verdict is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_fin) - 3'(out_fin);
		end
	end

	// Hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
		$stable(out_position) && $stable(out_value) && $stable(out_ok) && $stable(out_last))
		else $error("result word changed while stalled");

	// Queue comes out of reset empty
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered right after reset");

	// Verdict only after its final byte was taken
	a_verdict_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_fin |-> pending_q != 3'd0)
		else $error("verdict without a final byte");

	// Data words stay inside the coordinate and carry no verdict bits
	a_data_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind != KIND_VERDICT) |->
		(out_position < 6'(MAX_COORD_BYTES)) && !out_ok && !out_last)
		else $error("malformed data word");

endmodule

bind der_ecdsa_signature_parser_core desp_checker u_desp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sig.valid),
	.in_ready     (sig.ready),
	.in_is_last   (sig.is_last),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.out_kind     (res.kind),
	.out_position (res.position),
	.out_value    (res.value),
	.out_ok       (res.ok),
	.out_last     (res.last)
);

>>> tb/tb_der_ecdsa_signature_parser_core.sv
// ----------------------------------------------------------------------------
// tb_der_ecdsa_signature_parser_core
// Self-checking bench for the DER ECDSA signature parser. A queue-fed driver
// sends signature bytes, and a monitor decodes every accepted byte with its
// own DER decoder. It then compares each result word against the oldest
// predicted word. The run covers directed frames, then random frames per
// coordinate length. Random frames are built around the coordinate length,
// and a quarter of them are then corrupted or replaced by noise.
// ----------------------------------------------------------------------------
module tb_der_ecdsa_signature_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import desp_pkg::*;

	localparam int ITEMS       = 1050;
	localparam int NUM_PHASES  = 9;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 8;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
	} byte_item_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	coord_bytes_t cfg_wdata;

	desp_byte_if sig_ch();
	desp_res_if  res_ch();

	der_ecdsa_signature_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sig       (sig_ch),
		.res       (res_ch)
	);

	// Stimulus and scoreboard state
	byte_item_t pending_bytes[$];
	result_t    expected_words[$];
	logic [7:0] frame[$];
	logic [7:0] elems[$];

	int n_pushed, n_taken, n_live, n_frames, n_errors;
	int n_coord_words, n_verdicts, n_good_verdicts;
	int snd_idle_pct, rcv_idle_pct;
	int hold_asks, hold_seen, hold_left;
	bit byte_taken;

	// Decoder copy used for prediction
	parse_t       dec;
	coord_bytes_t dec_coord_bytes;

	int coord_plan[NUM_PHASES] = '{32, 1, 48, 0, 63, 49, 1, 1, 1};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Accept an integer length if it fits in what is left of the sequence
	task automatic set_int_len(input logic [31:0] v);
		if (v == 0 || v > dec.seq_left)
			dec.err = 1'b1;
		else begin
			dec.elem_left = v;
			dec.phase = PH_INT_FIRST;
		end
	endtask

	// Decode one accepted byte and queue the words it should produce
	task automatic predict_der_byte(input logic [7:0] b, input logic fin);
		result_t     w;
		logic [31:0] n;
		logic [31:0] diff;
		logic [6:0]  m;
		logic        go;
		logic        keep;
		w = '0;
		if (!dec.err) begin
			n_live++;
			go = 1'b1;
			keep = 1'b1;
			if (dec_coord_bytes == 0 || dec_coord_bytes > MAX_COORD_BYTES ||
				dec.phase == PH_DONE) begin
				dec.err = 1'b1;
				go = 1'b0;
			end else if (dec.phase >= PH_INT_TAG) begin
				if (dec.seq_left == 0) begin
					dec.err = 1'b1;
					go = 1'b0;
				end else
					dec.seq_left = dec.seq_left - 1;
			end
			if (go) begin
				case (dec.phase)
					PH_SEQ_TAG: begin
						go = 1'b0;
						if (b != TAG_SEQUENCE)
							dec.err = 1'b1;
						else
							dec.phase = PH_SEQ_LEN;
					end
					PH_INT_TAG: begin
						go = 1'b0;
						if (b != TAG_INTEGER)
							dec.err = 1'b1;
						else
							dec.phase = PH_INT_LEN;
					end
					PH_SEQ_LEN, PH_INT_LEN: begin
						go = 1'b0;
						m = b[6:0];
						if (b[7]) begin
							if (m == 0 || m > LONG_FORM_MAX)
								dec.err = 1'b1;
							else begin
								dec.len_left = m[2:0];
								dec.acc = '0;
								dec.phase = (dec.phase == PH_SEQ_LEN) ? PH_SEQ_LENX : PH_INT_LENX;
							end
						end else if (dec.phase == PH_SEQ_LEN) begin
							dec.seq_left = {24'd0, b};
							dec.phase = PH_INT_TAG;
						end else
							set_int_len({24'd0, b});
					end
					PH_SEQ_LENX, PH_INT_LENX: begin
						go = 1'b0;
						dec.acc = {dec.acc[23:0], b};
						dec.len_left = dec.len_left - 3'd1;
						if (dec.len_left == 0) begin
							if (dec.acc < LONG_FORM_MIN)
								dec.err = 1'b1;
							else if (dec.phase == PH_SEQ_LENX) begin
								dec.seq_left = dec.acc;
								dec.phase = PH_INT_TAG;
							end else
								set_int_len(dec.acc);
						end
					end
					PH_INT_FIRST: begin
						n = dec.elem_left;
						if (b[7]) begin
							dec.err = 1'b1;
							go = 1'b0;
						end else begin
							// drop one leading zero when more bytes follow
							if (n > 1 && b == 8'd0) begin
								keep = 1'b0;
								n = n - 1;
							end
							if (n > dec_coord_bytes) begin
								dec.err = 1'b1;
								go = 1'b0;
							end else begin
								diff = {26'd0, dec_coord_bytes} - n;
								dec.vpos = diff[5:0];
							end
						end
					end
					default: ;
				endcase
			end
			if (go) begin
				// advance through the integer body, then to s, then to the end
				dec.elem_left = dec.elem_left - 1;
				if (dec.elem_left != 0)
					dec.phase = PH_INT_BODY;
				else if (!dec.cur_int) begin
					dec.cur_int = 1'b1;
					dec.phase = PH_INT_TAG;
				end else begin
					dec.phase = PH_DONE;
					if (dec.seq_left != 0)
						dec.err = 1'b1;
				end
				if (keep && !dec.err) begin
					w.kind = (dec.phase != PH_INT_TAG && dec.cur_int) ? KIND_S : KIND_R;
					w.position = dec.vpos;
					w.value = b;
					expected_words.push_back(w);
					dec.vpos = dec.vpos + 6'd1;
				end
			end
		end
		if (fin) begin
			w = '0;
			w.kind = KIND_VERDICT;
			w.ok = !dec.err && dec.phase == PH_DONE && dec.seq_left == 0;
			w.last = 1'b1;
			expected_words.push_back(w);
			dec = PARSE_RESET;
		end
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			n_errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Monitor: predict on accepted bytes, then check accepted words
	always @(posedge clk) begin : observe
		result_t want;
		result_t got;
		byte_taken = 1'b0;
		if (arst_n) begin
			if (sig_ch.valid && sig_ch.ready) begin
				byte_taken = 1'b1;
				n_taken++;
				predict_der_byte(sig_ch.sig_byte, sig_ch.is_last);
			end
			if (res_ch.valid && res_ch.ready) begin
				got.kind = kind_t'(res_ch.kind);
				got.position = res_ch.position;
				got.value = res_ch.value;
				got.ok = res_ch.ok;
				got.last = res_ch.last;
				if (got.kind == KIND_VERDICT) begin
					n_verdicts++;
					if (got.ok)
						n_good_verdicts++;
				end else
					n_coord_words++;
				if (expected_words.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected word: expected none, actual kind=%0d pos=%0d value=%0d ok=%0b last=%0b",
						$time, got.kind, got.position, got.value, got.ok, got.last);
				end else begin
					want = expected_words.pop_front();
					check_field("kind", int'(want.kind), int'(got.kind));
					check_field("position", int'(want.position), int'(got.position));
					check_field("value", int'(want.value), int'(got.value));
					check_field("ok", int'(want.ok), int'(got.ok));
					check_field("last", int'(want.last), int'(got.last));
				end
			end
		end
	end

	// Driver: hold the current byte until taken, then offer the next or idle
	always @(negedge clk) begin : drive_bytes
		byte_item_t it;
		if (!arst_n)
			sig_ch.valid <= 1'b0;
		else if (!sig_ch.valid || byte_taken) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				it = pending_bytes.pop_front();
				sig_ch.valid <= 1'b1;
				sig_ch.sig_byte <= it.b;
				sig_ch.is_last <= it.fin;
			end else
				sig_ch.valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else
			res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	task automatic push_frame();
		byte_item_t it;
		for (int i = 0; i < frame.size(); i++) begin
			it.b = frame[i];
			it.fin = (i == frame.size() - 1);
			pending_bytes.push_back(it);
			n_pushed++;
		end
		n_frames++;
	endtask

	// Append one INTEGER element sized around the coordinate length
	task automatic add_integer(input int c);
		logic [7:0] body[$];
		int nv;
		body = {};
		case ($urandom_range(9))
			0:       nv = c + 1;
			1, 2, 3: nv = $urandom_range(1, c);
			default: nv = c;
		endcase
		for (int i = 0; i < nv; i++)
			body.push_back(8'($urandom_range(255)));
		if ($urandom_range(9) == 0)
			body[0] = 8'd0;
		if (body[0][7]) begin
			if ($urandom_range(99) < 85)
				body.push_front(8'd0);
		end else if ($urandom_range(9) == 0)
			body.push_front(8'd0);
		elems.push_back(TAG_INTEGER);
		elems.push_back(8'(body.size()));
		elems = {elems, body};
	endtask

	// Break a frame in one of several ways
	task automatic corrupt_frame();
		int k;
		int m;
		m = $urandom_range(7);
		case ($urandom_range(5))
			0: begin
				k = $urandom_range(1, frame.size() - 1);
				while (frame.size() > k)
					frame.delete(frame.size() - 1);
			end
			1: repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(255)));
			2: begin
				k = $urandom_range(frame.size() - 1);
				frame[k] = 8'($urandom_range(255));
			end
			3: frame[1] = frame[1] + ($urandom_range(1) ? 8'd1 : 8'hFF);
			4: begin
				// long-form sequence length with a random count
				frame = {};
				frame.push_back(TAG_SEQUENCE);
				frame.push_back(8'h80 | 8'(m));
				repeat (m) frame.push_back($urandom_range(1) ? 8'($urandom_range(255)) :
					8'(elems.size()));
				frame = {frame, elems};
			end
			default: begin
				// long-form integer length, then noise
				frame = {};
				frame.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255)) : TAG_SEQUENCE);
				frame.push_back(8'h81);
				frame.push_back(8'($urandom_range(128, 255)));
				frame.push_back(TAG_INTEGER);
				frame.push_back(8'h80 | 8'(m));
				repeat ($urandom_range(0, 6)) frame.push_back(8'($urandom_range(255)));
			end
		endcase
	endtask

	task automatic gen_signature();
		int c;
		c = (dec_coord_bytes >= 1 && dec_coord_bytes <= MAX_COORD_BYTES) ?
			int'(dec_coord_bytes) : $urandom_range(1, MAX_COORD_BYTES);
		elems = {};
		add_integer(c);
		add_integer(c);
		frame = {};
		frame.push_back(TAG_SEQUENCE);
		frame.push_back(8'(elems.size()));
		frame = {frame, elems};
		if ($urandom_range(99) < 25)
			corrupt_frame();
		push_frame();
	endtask

	// Wait until every byte is taken and every word has arrived
	task automatic drain_all();
		while (pending_bytes.size() != 0 || n_taken != n_pushed || expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_coord_bytes(input coord_bytes_t v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		dec_coord_bytes = v;
	endtask

	initial begin : stimulus
		int nsig;
		int max_sig;
		int start_pushed;
		int budget;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sig_ch.valid = 1'b0;
		sig_ch.sig_byte = '0;
		sig_ch.is_last = 1'b0;
		res_ch.ready = 1'b0;
		dec = PARSE_RESET;
		dec_coord_bytes = COORD_BYTES_RESET;
		budget = ITEMS / NUM_PHASES;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			snd_idle_pct = (p < 3) ? 31 : (p < 6) ? 66 : 0;
			rcv_idle_pct = (p < 3) ? 66 : (p < 6) ? 31 : 0;
			if (p > 0) begin
				drain_all();
				if (p >= 6)
					coord_plan[p] = $urandom_range(1, MAX_COORD_BYTES);
				write_coord_bytes(coord_bytes_t'(coord_plan[p]));
			end
			if (p == 0) begin
				// zero integers kept, leading zero dropped before a high byte
				frame = {8'h30, 8'h06, 8'h02, 8'h01, 8'h00, 8'h02, 8'h01, 8'h7F};
				push_frame();
				frame = {8'h30, 8'h08, 8'h02, 8'h02, 8'h00, 8'h80, 8'h02, 8'h02,
					8'h00, 8'hFF};
				push_frame();
				// negative integer
				frame = {8'h30, 8'h03, 8'h02, 8'h01, 8'h80};
				push_frame();
				// long form with a zero count
				frame = {8'h30, 8'h80};
				push_frame();
			end
			start_pushed = n_pushed;
			nsig = 0;
			max_sig = (dec_coord_bytes >= 1 && dec_coord_bytes <= MAX_COORD_BYTES) ? 400 : 1;
			while (n_pushed - start_pushed < budget && nsig < max_sig) begin
				if (p == 7 && nsig == 1)
					hold_asks++;
				if (p == 7 && nsig == 12)
					drain_all();
				while (pending_bytes.size() >= 24)
					@(posedge clk);
				gen_signature();
				nsig++;
			end
		end
		drain_all();

		$display("Covered %0d frames (%0d bytes, %0d decoded) over %0d coordinate lengths.",
			n_frames, n_taken, n_live, NUM_PHASES);
		$display("Checked %0d coordinate words and %0d verdicts, %0d of them well formed.",
			n_coord_words, n_verdicts, n_good_verdicts);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
